FILE: rtl/fpsalu_pkg.sv
// shared opcodes and configuration constants of the fixed-point saturating alu
package fpsalu_pkg;

    typedef logic [2:0] cmd_t;

    localparam cmd_t CMD_ADD    = 3'd0;
    localparam cmd_t CMD_SUB    = 3'd1;
    localparam cmd_t CMD_MUL    = 3'd2;
    localparam cmd_t CMD_DIV    = 3'd3;
    localparam cmd_t CMD_TO_INT = 3'd4;

    localparam int FRAC_W       = 5;
    localparam int FRAC_MAX     = 31;
    localparam int PADDR_W      = 3;
    localparam logic [PADDR_W-1:0] ADDR_QFRAC = 3'd0;
    localparam logic [FRAC_W-1:0]  FRAC_RESET = 5'd8;

endpackage

FILE: rtl/fixed_point_saturating_alu.sv
// fixed-point saturating alu: pipelined add, subtract, multiply, divide and to-integer
//
// usage: the s_ channel takes one request per cycle while s_ready is high (cmd, operand_a, operand_b);
// the m_ channel returns one result and status per request, in request order.
// operands are raw Q-format values; the number of fraction bits is set through
// the apb port at address 0 (reset value 8); write it only while the block is idle.
// pipeline depth is set by the restoring divider that resolves one quotient bit per pipeline
// stage over DATA_WIDTH + 31 stages; every operation runs through the same stages.
// throughput: one request per cycle while the result channel does not stall.
// stall: when m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
// reset: aresetn (synchronous, active low) empties the pipeline and sets the
// fraction width back to 8.
// status is 1 only for division by zero (result 0); codes 5 to 7 give 0 and ok.
module fixed_point_saturating_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_cmd,
    input  logic signed [31:0]                    s_operand_a,
    input  logic signed [31:0]                    s_operand_b,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [31:0]                    m_result,
    output logic                                  m_status,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fpsalu_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int W  = DATA_WIDTH;
    localparam int QW = DATA_WIDTH + fpsalu_pkg::FRAC_MAX;
    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

    // configuration register
    logic [fpsalu_pkg::FRAC_W-1:0] qfrac_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == fpsalu_pkg::ADDR_QFRAC) ?
                    32'(qfrac_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qfrac_reg <= fpsalu_pkg::FRAC_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr == fpsalu_pkg::ADDR_QFRAC) begin
            qfrac_reg <= pwdata[fpsalu_pkg::FRAC_W-1:0];
        end
    end

    // global pipeline advance
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 0: capture request
    logic                  v0_reg;
    fpsalu_pkg::cmd_t      cmd0_reg;
    logic signed [W-1:0]   a0_reg, b0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd0_reg <= s_cmd;
            a0_reg   <= s_operand_a[W-1:0];
            b0_reg   <= s_operand_b[W-1:0];
        end
    end

    // stage 1: simple ops, product, divider operand setup
    logic                   pv_reg   [QW+1];
    fpsalu_pkg::cmd_t       pcmd_reg [QW+1];
    logic signed [W-1:0]    pres_reg [QW+1];
    logic [W-1:0]           prem_reg [QW+1];
    logic [QW-1:0]          pnq_reg  [QW+1];
    logic [W-1:0]           pden_reg [QW+1];
    logic                   pneg_reg [QW+1];
    logic                   pdz_reg  [QW+1];
    logic signed [2*W-1:0]  prod1_reg;

    logic signed [W-1:0] res1_next;
    logic [W-1:0]        mag_a, mag_b;

    always_comb begin
        mag_a = a0_reg[W-1] ? W'(-a0_reg) : W'(a0_reg);
        mag_b = b0_reg[W-1] ? W'(-b0_reg) : W'(b0_reg);
        case (cmd0_reg)
            fpsalu_pkg::CMD_ADD:    res1_next = a0_reg + b0_reg;
            fpsalu_pkg::CMD_SUB:    res1_next = a0_reg - b0_reg;
            fpsalu_pkg::CMD_TO_INT: res1_next = a0_reg >>> qfrac_reg;
            default:                res1_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg[0] <= 1'b0;
        end else if (en) begin
            pv_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pcmd_reg[0] <= cmd0_reg;
            pres_reg[0] <= res1_next;
            prod1_reg   <= (2*W)'(a0_reg) * (2*W)'(b0_reg);
            prem_reg[0] <= '0;
            pnq_reg[0]  <= QW'(mag_a) << qfrac_reg;
            pden_reg[0] <= mag_b;
            pneg_reg[0] <= a0_reg[W-1] ^ b0_reg[W-1];
            pdz_reg[0]  <= (b0_reg == '0);
        end
    end

    // multiply shift and saturate, folded into the first divider stage
    logic signed [2*W-1:0] prod_sh;
    logic signed [W-1:0]   mul_res;

    always_comb begin
        prod_sh = prod1_reg >>> qfrac_reg;
        if (prod_sh > (2*W)'(S_MAX)) begin
            mul_res = S_MAX;
        end else if (prod_sh < (2*W)'(S_MIN)) begin
            mul_res = S_MIN;
        end else begin
            mul_res = prod_sh[W-1:0];
        end
    end

    // restoring divider, one quotient bit per stage
    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_div
            logic [W:0]   trial;
            logic [W:0]   diff;
            logic         qbit;
            logic [W-1:0] rem_next;

            always_comb begin
                trial    = {prem_reg[k], pnq_reg[k][QW-1]};
                diff     = trial - {1'b0, pden_reg[k]};
                qbit     = (trial >= {1'b0, pden_reg[k]});
                rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    pv_reg[k+1] <= 1'b0;
                end else if (en) begin
                    pv_reg[k+1] <= pv_reg[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    pcmd_reg[k+1] <= pcmd_reg[k];
                    if (k == 0 && pcmd_reg[k] == fpsalu_pkg::CMD_MUL) begin
                        pres_reg[k+1] <= mul_res;
                    end else begin
                        pres_reg[k+1] <= pres_reg[k];
                    end
                    prem_reg[k+1] <= rem_next;
                    pnq_reg[k+1]  <= {pnq_reg[k][QW-2:0], qbit};
                    pden_reg[k+1] <= pden_reg[k];
                    pneg_reg[k+1] <= pneg_reg[k];
                    pdz_reg[k+1]  <= pdz_reg[k];
                end
            end
        end
    endgenerate

    // final stage: quotient sign and saturation, output register
    logic [QW-1:0]       quo;
    logic signed [W-1:0] div_res;
    logic signed [W-1:0] fin_res;
    logic                fin_status;

    always_comb begin
        quo = pnq_reg[QW];
        if (!pneg_reg[QW]) begin
            div_res = (quo > QW'(S_MAX)) ? S_MAX : quo[W-1:0];
        end else begin
            // negative quotient magnitude may reach 2^(W-1)
            div_res = (quo > QW'({1'b0, S_MIN})) ? S_MIN : W'(-quo[W-1:0]);
        end
        fin_res    = pres_reg[QW];
        fin_status = 1'b0;
        if (pcmd_reg[QW] == fpsalu_pkg::CMD_DIV) begin
            if (pdz_reg[QW]) begin
                fin_res    = '0;
                fin_status = 1'b1;
            end else begin
                fin_res = div_res;
            end
        end
    end

    logic signed [31:0] m_result_reg;
    logic               m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= pv_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_result_reg <= 32'(fin_res);
            m_status_reg <= fin_status;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign m_status = m_status_reg;

endmodule

FILE: bench/testbench.sv
// testbench of the fixed-point saturating alu: random and directed requests against a predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        fpsalu_pkg::cmd_t   cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               status;
    } alu_res_t;

    localparam int LATENCY  = 65;
    localparam int WDOG_MAX = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_taken = 1'b0;
    logic [2:0] s_cmd = '0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_result;
    logic m_status;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [fpsalu_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    fixed_point_saturating_alu u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result), .m_status(m_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 aclk = ~aclk;

    alu_req_t pending_reqs[$];
    alu_res_t expected_results[$];
    logic [fpsalu_pkg::FRAC_W-1:0] frac_cfg = fpsalu_pkg::FRAC_RESET;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    // predicted alu result for the current fraction setting
    function automatic alu_res_t alu_predict(alu_req_t r);
        alu_res_t o;
        logic signed [63:0] a64, b64, t;
        a64 = r.a;
        b64 = r.b;
        o.status = 1'b0;
        t = '0;
        case (r.cmd)
            fpsalu_pkg::CMD_ADD: t = a64 + b64;
            fpsalu_pkg::CMD_SUB: t = a64 - b64;
            fpsalu_pkg::CMD_MUL: t = (a64 * b64) >>> frac_cfg;
            fpsalu_pkg::CMD_DIV: begin
                if (r.b == 0) begin
                    o.status = 1'b1;
                    t = '0;
                end else begin
                    t = (a64 <<< frac_cfg) / b64;
                end
            end
            fpsalu_pkg::CMD_TO_INT: t = a64 >>> frac_cfg;
            default: t = '0;
        endcase
        // saturate multiply and divide, the others wrap
        if (r.cmd == fpsalu_pkg::CMD_MUL || r.cmd == fpsalu_pkg::CMD_DIV) begin
            if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
            else if (t < -64'sh80000000) t = -64'sh80000000;
        end
        o.result = t[31:0];
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(0, 8)) - 4);
            3: return 32'($urandom_range(0, 4095)) << $urandom_range(0, 20);
            4: return -(32'($urandom_range(0, 4095)) << $urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_cmd <= pending_reqs[0].cmd;
                    s_operand_a <= pending_reqs[0].a;
                    s_operand_b <= pending_reqs[0].b;
                    void'(pending_reqs.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // request predictor and result checker
    always @(posedge aclk) begin
        alu_res_t exp_res;
        s_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.push_back(alu_predict('{s_cmd, s_operand_a, s_operand_b}));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h status %b", m_result, m_status);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.result !== m_result || exp_res.status !== m_status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%b got %h/%b",
                                     exp_res.result, exp_res.status, m_result, m_status);
                    end
                end
            end
            // watchdog on cycles without any accepted request or result
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    task automatic frac_write(input logic [fpsalu_pkg::FRAC_W-1:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= fpsalu_pkg::ADDR_QFRAC;
        pwdata <= 32'(v);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        frac_cfg = v;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic queue_random(input int n);
        alu_req_t r;
        repeat (n) begin
            r.cmd = ($urandom_range(0, 19) == 0) ? fpsalu_pkg::cmd_t'($urandom_range(5, 7))
                                                  : fpsalu_pkg::cmd_t'($urandom_range(0, 4));
            r.a = rand_operand();
            r.b = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_operand();
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        logic [fpsalu_pkg::FRAC_W-1:0] frac_list[6];
        logic signed [31:0] edge_vals[4];
        frac_list = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd8, 5'd24};
        edge_vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, every opcode, zero divisor, unused codes
        for (int c = 0; c < 8; c++)
            pending_reqs.push_back('{fpsalu_pkg::cmd_t'(c), edge_vals[c % 4],
                                     edge_vals[(c + 1) % 4]});
        pending_reqs.push_back('{fpsalu_pkg::CMD_DIV, 32'sh12345678, 32'sd0});
        pending_reqs.push_back('{fpsalu_pkg::CMD_DIV, 32'sh80000000, -32'sd1});
        pending_reqs.push_back('{fpsalu_pkg::CMD_MUL, 32'sh80000000, 32'sh80000000});
        pending_reqs.push_back('{fpsalu_pkg::CMD_MUL, 32'sh7FFFFFFF, 32'sh80000000});
        pending_reqs.push_back('{fpsalu_pkg::CMD_DIV, -32'sd7, 32'sd2});
        pending_reqs.push_back('{fpsalu_pkg::CMD_TO_INT, -32'sd1, 32'sh7FFFFFFF});
        pending_reqs.push_back('{fpsalu_pkg::CMD_ADD, 32'sh7FFFFFFF, 32'sd1});
        pending_reqs.push_back('{fpsalu_pkg::CMD_SUB, 32'sh80000000, 32'sd1});
        drain();

        // random phases across fraction settings and idling patterns
        for (int p = 0; p < 6; p++) begin
            frac_write(frac_list[p]);
            pending_reqs.push_back('{fpsalu_pkg::CMD_DIV, 32'sh7FFFFFFF, 32'sd1});
            pending_reqs.push_back('{fpsalu_pkg::CMD_TO_INT, 32'sh80000000, 32'sd0});
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            queue_random(105);
            drain();
        end
        frac_write(fpsalu_pkg::FRAC_W'($urandom_range(0, fpsalu_pkg::FRAC_MAX)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(10);
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
